@@ rtl/core/sdsse_pkg.sv @@
// ----------------------------------------------------------------------------
// sdsse_pkg
// Shared types, constants and the seven-segment table for the signed decimal
// seven-segment encoder.
// ----------------------------------------------------------------------------
package sdsse_pkg;

  localparam int MagWidth     = 32;
  localparam int CntWidth     = $clog2(MagWidth);
  localparam int CodeWidth    = 4;
  localparam int SegWidth     = 7;
  localparam int MaxBcdDigits = 10;

  localparam logic [CodeWidth-1:0] GlyphMinus = 4'd10;

  typedef enum logic [2:0] {
    StIdle,
    StSat,
    StConv,
    StSkip,
    StSign,
    StDigit
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sat;
    logic shift;
    logic dec;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;
    logic cnt_last;
    logic idx_zero;
    logic digit_zero;
  } dp_status_t;

  // 10**n - 1, evaluated at elaboration.
  function automatic logic [63:0] pow10_minus1(input int n);
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 0; i < n; i++) begin
      acc = acc * 64'd10;
    end
    return acc - 64'd1;
  endfunction

  // Bit 0 top, 1 upper right, 2 lower right, 3 bottom, 4 lower left,
  // 5 upper left, 6 middle.
  function automatic logic [SegWidth-1:0] seg_of(input logic [CodeWidth-1:0] code);
    logic [SegWidth-1:0] seg;
    unique case (code)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h40;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/core/sdsse_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdsse_ctrl
// Controller state machine: load, clamp, shift-add-3 conversion, leading zero
// skip and glyph emission.
// ----------------------------------------------------------------------------
module sdsse_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  sdsse_pkg::dp_status_t status_i,
  output sdsse_pkg::dp_cmd_t    cmd_o
);
  import sdsse_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) state_d = StSat;
      end
      StSat:  state_d = StConv;
      StConv: begin
        if (status_i.cnt_last) state_d = StSkip;
      end
      StSkip: begin
        if (!status_i.digit_zero || status_i.idx_zero) begin
          state_d = status_i.neg ? StSign : StDigit;
        end
      end
      StSign: state_d = StDigit;
      StDigit: begin
        if (status_i.idx_zero) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      StSat:  cmd_o.sat = 1'b1;
      StConv: cmd_o.shift = 1'b1;
      StSkip: begin
        cmd_o.dec = status_i.digit_zero && !status_i.idx_zero;
      end
      StSign: cmd_o.emit_sign = 1'b1;
      StDigit: begin
        cmd_o.emit_digit = 1'b1;
        cmd_o.dec        = !status_i.idx_zero;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

@@ rtl/core/sdsse_dp.sv @@
// ----------------------------------------------------------------------------
// sdsse_dp
// Datapath: magnitude and sign registers, saturation, shift-add-3 BCD
// register, digit pointer and the registered glyph output.
// ----------------------------------------------------------------------------
module sdsse_dp #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [sdsse_pkg::MagWidth-1:0] value_i,
  input  sdsse_pkg::dp_cmd_t                   cmd_i,
  output sdsse_pkg::dp_status_t                status_o,
  output logic                                 strobe_o,
  output logic [sdsse_pkg::CodeWidth-1:0]      glyph_code_o,
  output logic [sdsse_pkg::SegWidth-1:0]       segment_bits_o,
  output logic                                 last_glyph_o
);
  import sdsse_pkg::*;

  // A 32-bit magnitude never needs more than ten digits.
  localparam int NumDigits = (MAX_DIGITS < MaxBcdDigits) ? MAX_DIGITS : MaxBcdDigits;
  localparam int BcdWidth  = NumDigits * 4;
  localparam int IdxWidth  = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam logic [63:0] Limit = pow10_minus1(MAX_DIGITS);

  logic [MagWidth-1:0]  mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic [BcdWidth-1:0]  bcd_q, bcd_d, bcd_adj;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [IdxWidth-1:0]  idx_q, idx_d;
  logic [CodeWidth-1:0] digit;
  logic                 strobe_q, strobe_d;
  logic [CodeWidth-1:0] code_q, code_d;
  logic [SegWidth-1:0]  seg_q, seg_d;
  logic                 last_q, last_d;

  assign digit = bcd_q[{idx_q, 2'b00} +: 4];

  // Add 3 to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                     : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    mag_d    = mag_q;
    neg_d    = neg_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    strobe_d = 1'b0;
    code_d   = code_q;
    seg_d    = seg_q;
    last_d   = last_q;
    if (cmd_i.load) begin
      neg_d = value_i[MagWidth-1];
      // Two's complement negation also gives the right magnitude for the
      // most negative value when read as unsigned.
      mag_d = value_i[MagWidth-1] ? MagWidth'(-value_i) : MagWidth'(value_i);
      bcd_d = '0;
      cnt_d = '0;
      idx_d = IdxWidth'(NumDigits - 1);
    end
    if (cmd_i.sat) begin
      if ({32'd0, mag_q} > Limit) mag_d = Limit[MagWidth-1:0];
    end
    if (cmd_i.shift) begin
      bcd_d = {bcd_adj[BcdWidth-2:0], mag_q[MagWidth-1]};
      mag_d = {mag_q[MagWidth-2:0], 1'b0};
      cnt_d = cnt_q + CntWidth'(1);
    end
    if (cmd_i.dec) begin
      idx_d = idx_q - IdxWidth'(1);
    end
    if (cmd_i.emit_sign) begin
      strobe_d = 1'b1;
      code_d   = GlyphMinus;
      seg_d    = seg_of(GlyphMinus);
      last_d   = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      strobe_d = 1'b1;
      code_d   = digit;
      seg_d    = seg_of(digit);
      last_d   = (idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    code_q <= code_d;
    seg_q  <= seg_d;
    last_q <= last_d;
  end

  assign status_o.neg        = neg_q;
  assign status_o.cnt_last   = (cnt_q == CntWidth'(MagWidth - 1));
  assign status_o.idx_zero   = (idx_q == '0);
  assign status_o.digit_zero = (digit == '0);

  assign strobe_o       = strobe_q;
  assign glyph_code_o   = code_q;
  assign segment_bits_o = seg_q;
  assign last_glyph_o   = last_q;

endmodule

@@ rtl/core/signed_decimal_seven_segment_encoder.sv @@
// A value passes load, clamp, the 32-step BCD shift loop, then one step per digit
// position (leading zeros included) plus one for a minus sign; a new value is taken
// only from idle, after the last glyph, while busy is low.
// Each glyph is on the outputs for one cycle with strobe_o; no back pressure.
// Reset is asynchronous and active low; it returns the controller to idle.
// ----------------------------------------------------------------------------
// signed_decimal_seven_segment_encoder
// Turns a signed 32-bit integer into a run of seven-segment glyphs, minus sign
// first for negative values, then the digits without leading zeros.
// ----------------------------------------------------------------------------
module signed_decimal_seven_segment_encoder #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sdsse_pkg::MagWidth-1:0] value_i,
  output logic                                 strobe_o,
  output logic [sdsse_pkg::CodeWidth-1:0]      glyph_code_o,
  output logic [sdsse_pkg::SegWidth-1:0]       segment_bits_o,
  output logic                                 last_glyph_o
);
  import sdsse_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sdsse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  sdsse_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .strobe_o       (strobe_o),
    .glyph_code_o   (glyph_code_o),
    .segment_bits_o (segment_bits_o),
    .last_glyph_o   (last_glyph_o)
  );

endmodule
